>>> design/lss_pkg.sv
// ----------------------------------------------------------------------------
// lss_pkg
// Shared types and constants for the LIFO stack with search.
// ----------------------------------------------------------------------------
package lss_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned COUNT_W  = 9;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH   = 2'd0,
    ACT_POP    = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_CLEAR  = 2'd3
  } act_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_MISSING = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SCAN
  } state_t;

  // Scan unit status toward the sequencer.
  typedef struct packed {
    logic hit;      // word under compare equals the key
    logic at_last;  // word under compare is the top entry
  } scan_t;

endpackage

>>> design/lss_ram.sv
// ----------------------------------------------------------------------------
// lss_ram
// Entry store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lss_ram
  import lss_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [WORD_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [WORD_W-1:0] rdata
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> design/lss_scan.sv
// ----------------------------------------------------------------------------
// lss_scan
// Search unit: holds the key and the scan index, one equality compare per
// cycle against the word read from the store.
// ----------------------------------------------------------------------------
module lss_scan
  import lss_pkg::*;
#(
  parameter int unsigned AW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  logic              step,
  input  logic [WORD_W-1:0] key,
  input  logic [WORD_W-1:0] rdata,
  input  logic [AW-1:0]     last_idx,
  output scan_t             scan,
  output logic [AW-1:0]     idx,
  output logic [AW-1:0]     next_addr
);

  logic [WORD_W-1:0] key_r;
  logic [AW-1:0]     idx_r;
  logic [AW-1:0]     idx_nxt;

  assign next_addr = idx_r + AW'(1);

  always_comb begin
    idx_nxt = idx_r;
    if (load) begin
      idx_nxt = '0;
    end else if (step) begin
      idx_nxt = next_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_r <= key;
    end
  end

  assign scan.hit     = (rdata == key_r);
  assign scan.at_last = (idx_r == last_idx);
  assign idx          = idx_r;

endmodule

>>> design/lifo_stack_with_search_unit.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_search_unit
// Fixed-depth LIFO of signed 32-bit words with push, pop, clear and a
// bottom-up search for the first entry equal to a key.
// ----------------------------------------------------------------------------
// Push, clear and rejected actions finish without raising busy; a pop passes
// through S_POP. Search compares from the bottom up, paced by the single read
//   port of the entry store, one word a cycle, and ends on a match or the top.
// One push or clear per cycle; busy during pop and search blocks new actions.
// Reset (rst_n low, synchronous) empties the stack; stored words are kept.
// The receiver cannot stall: each result shows for one cycle.
// ----------------------------------------------------------------------------
module lifo_stack_with_search_unit
  import lss_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  // command side
  input  logic                     start,
  output logic                     busy,
  input  logic [ACTION_W-1:0]      in_action,
  input  logic signed [WORD_W-1:0] in_value,
  // result side
  output logic                     out_valid,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [WORD_W-1:0] out_data_word,
  output logic [POS_W-1:0]         out_position,
  output logic [COUNT_W-1:0]       out_count,
  output logic                     out_is_empty,
  output logic signed [WORD_W-1:0] out_top_word
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Sequencer state and stack bookkeeping
  state_t            state_r, state_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;       // entries held
  logic [WORD_W-1:0] top_r, top_nxt;       // top entry, zero when empty

  // Result register
  logic              out_valid_r;
  status_t           res_status_r;
  logic [WORD_W-1:0] res_data_r;
  logic [POS_W-1:0]  res_pos_r;
  logic [CW-1:0]     res_cnt_r;
  logic [WORD_W-1:0] res_top_r;

  // Result being formed this cycle
  logic              fin;
  status_t           fin_status;
  logic [WORD_W-1:0] fin_data;
  logic [POS_W-1:0]  fin_pos;

  // Store and scan unit hookup
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;
  logic              scan_load;
  logic              scan_step;
  scan_t             scan;
  logic [AW-1:0]     scan_idx;
  logic [AW-1:0]     scan_next;
  logic [CW-1:0]     cnt_m1;
  logic [CW-1:0]     cnt_m2;

  logic              accept;
  act_t              act;
  logic              full;
  logic              empty;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;
  assign act    = act_t'(in_action);
  assign full   = (cnt_r == CW'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign cnt_m1 = cnt_r - CW'(1);
  assign cnt_m2 = cnt_r - CW'(2);

  lss_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lss_scan #(
    .AW (AW)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (scan_load),
    .step      (scan_step),
    .key       (in_value),
    .rdata     (ram_rdata),
    .last_idx  (cnt_m1[AW-1:0]),
    .scan      (scan),
    .idx       (scan_idx),
    .next_addr (scan_next)
  );

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && act == ACT_POP && !empty) begin
          state_nxt = S_POP;
        end else if (accept && act == ACT_SEARCH && !empty) begin
          state_nxt = S_SCAN;
        end
      end
      S_POP: begin
        state_nxt = S_IDLE;
      end
      S_SCAN: begin
        if (scan.hit || scan.at_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer outputs and datapath control
  // --------------------------------------------------------------------------
  always_comb begin
    cnt_nxt    = cnt_r;
    top_nxt    = top_r;
    fin        = 1'b0;
    fin_status = ST_OK;
    fin_data   = '0;
    fin_pos    = '0;
    ram_we     = 1'b0;
    ram_waddr  = cnt_r[AW-1:0];
    ram_raddr  = '0;
    scan_load  = 1'b0;
    scan_step  = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (act)
            ACT_PUSH: begin
              fin = 1'b1;
              if (full) begin
                fin_status = ST_FULL;
              end else begin
                ram_we  = 1'b1;
                cnt_nxt = cnt_r + CW'(1);
                top_nxt = in_value;
              end
            end
            ACT_POP: begin
              if (empty) begin
                fin        = 1'b1;
                fin_status = ST_EMPTY;
              end else begin
                // fetch the entry that becomes the new top
                ram_raddr = cnt_m2[AW-1:0];
                cnt_nxt   = cnt_m1;
              end
            end
            ACT_SEARCH: begin
              if (empty) begin
                fin        = 1'b1;
                fin_status = ST_MISSING;
              end else begin
                ram_raddr = '0;
                scan_load = 1'b1;
              end
            end
            ACT_CLEAR: begin
              fin     = 1'b1;
              cnt_nxt = '0;
              top_nxt = '0;
            end
            default: begin
              fin = 1'b0;
            end
          endcase
        end
      end
      S_POP: begin
        // count already decremented; old top is the popped word
        fin      = 1'b1;
        fin_data = top_r;
        top_nxt  = empty ? '0 : ram_rdata;
      end
      S_SCAN: begin
        ram_raddr = scan_next;
        if (scan.hit) begin
          fin     = 1'b1;
          fin_pos = POS_W'(scan_idx);
        end else if (scan.at_last) begin
          fin        = 1'b1;
          fin_status = ST_MISSING;
        end else begin
          scan_step = 1'b1;
        end
      end
      default: begin
        fin = 1'b0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      top_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      top_r       <= top_nxt;
      out_valid_r <= fin;
    end
  end

  // result payload follows the count and top as they stand after the action
  always_ff @(posedge clk) begin
    if (fin) begin
      res_status_r <= fin_status;
      res_data_r   <= fin_data;
      res_pos_r    <= fin_pos;
      res_cnt_r    <= cnt_nxt;
      res_top_r    <= top_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = res_status_r;
  assign out_data_word = res_data_r;
  assign out_position  = res_pos_r;
  assign out_count     = COUNT_W'(res_cnt_r);
  assign out_is_empty  = (res_cnt_r == '0);
  assign out_top_word  = res_top_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH))
    else $error("fill count above depth");

  a_no_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ram_we)
    else $error("store written while busy");

  a_pop_done: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POP |=> out_valid && state_r == S_IDLE)
    else $error("pop did not finish in one cycle");

  a_scan_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan.at_last) |=> out_valid && state_r == S_IDLE)
    else $error("scan ran past the top entry");

  a_quick_done: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (act == ACT_PUSH || act == ACT_CLEAR)) |=> out_valid && !busy)
    else $error("push or clear result missing");

endmodule

>>> bench/tb_lifo_stack_with_search_unit.sv
// ----------------------------------------------------------------------------
// tb_lifo_stack_with_search_unit
// Self-checking bench for the LIFO stack with search. Actions go in through
// the start/busy command port. An in-bench stack model predicts every result,
// and each out_valid strobe is checked field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module tb_lifo_stack_with_search_unit;
  import lss_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH    = 256;
  localparam int unsigned WATCHDOG_LIMIT = 4000;            // idle cycles before giving up
  localparam int unsigned DRAIN_CYCLES   = STACK_DEPTH + 4; // longest scan plus margin

  // One expected result, laid out like the result port
  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   data;
    logic [POS_W-1:0]    pos;
    logic [COUNT_W-1:0]  count;
    logic                empty;
    logic [WORD_W-1:0]   top;
  } stack_reply_t;

  // DUT connections: every input has a known value from time zero
  logic                     clk;
  logic                     rst_n     = 1'b0;
  logic                     start     = 1'b0;
  logic [ACTION_W-1:0]      in_action = ACT_PUSH;
  logic signed [WORD_W-1:0] in_value  = '0;
  logic                     busy;
  logic                     out_valid;
  logic [STATUS_W-1:0]      out_status;
  logic signed [WORD_W-1:0] out_data_word;
  logic [POS_W-1:0]         out_position;
  logic [COUNT_W-1:0]       out_count;
  logic                     out_is_empty;
  logic signed [WORD_W-1:0] out_top_word;

  // Stack model state: only entries below stack_fill are ever read
  logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
  int unsigned       stack_fill = 0;

  stack_reply_t pending_replies[$];

  // Sender idle probability in percent, per cycle
  int unsigned idle_pct = 0;

  // Bookkeeping for the closing summary
  int unsigned mismatches    = 0;
  int unsigned replies_seen  = 0;
  int unsigned n_push        = 0;
  int unsigned n_pop         = 0;
  int unsigned n_search      = 0;
  int unsigned n_clear       = 0;
  int unsigned n_full_reject = 0;
  int unsigned n_empty_pop   = 0;
  int unsigned n_search_hit  = 0;
  int unsigned n_search_miss = 0;
  int unsigned deepest_hit   = 0;
  int unsigned idle_cycles   = 0;

  lifo_stack_with_search_unit #(
    .DEPTH(STACK_DEPTH)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_action    (in_action),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_data_word(out_data_word),
    .out_position (out_position),
    .out_count    (out_count),
    .out_is_empty (out_is_empty),
    .out_top_word (out_top_word)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // --------------------------------------------------------------------------
  // Stack model: applies one action to the model state and returns the
  // result the DUT should produce for it.
  // --------------------------------------------------------------------------
  function automatic stack_reply_t stack_apply(act_t act, logic [WORD_W-1:0] word);
    stack_reply_t r;
    bit           found;
    r        = '0;
    r.status = ST_OK;
    found    = 1'b0;
    case (act)
      ACT_PUSH: begin
        n_push++;
        if (stack_fill >= STACK_DEPTH) begin
          r.status = ST_FULL;
          n_full_reject++;
        end else begin
          stack_mem[stack_fill] = word;
          stack_fill++;
        end
      end
      ACT_POP: begin
        n_pop++;
        if (stack_fill == 0) begin
          r.status = ST_EMPTY;
          n_empty_pop++;
        end else begin
          stack_fill--;
          r.data = stack_mem[stack_fill];
        end
      end
      ACT_SEARCH: begin
        // bottom-up scan, lowest matching position wins
        n_search++;
        r.status = ST_MISSING;
        for (int i = 0; i < stack_fill && !found; i++) begin
          if (stack_mem[i] == word) begin
            found    = 1'b1;
            r.status = ST_OK;
            r.pos    = POS_W'(i);
            if (i > deepest_hit) deepest_hit = i;
          end
        end
        if (found) n_search_hit++;
        else n_search_miss++;
      end
      default: begin
        // clear: words stay in memory but become unreachable
        n_clear++;
        stack_fill = 0;
      end
    endcase
    r.count = COUNT_W'(stack_fill);
    r.empty = (stack_fill == 0);
    if (stack_fill > 0) r.top = stack_mem[stack_fill-1];
    return r;
  endfunction

  // Word mix: small values of both signs for duplicates, the extremes, and
  // full-range random words
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(7))
      0: return {29'd0, 3'($urandom_range(7))};
      1: return {{29{1'b1}}, 3'($urandom_range(7))};
      2: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7fff_ffff;
          2: return 32'hffff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      default: return $urandom();
    endcase
  endfunction

  // Search keys: mostly a word that is on the stack, so scans end at
  // varying depths; the rest random and mostly misses
  function automatic logic [WORD_W-1:0] pick_key();
    if (stack_fill > 0 && $urandom_range(9) < 6)
      return stack_mem[$urandom_range(stack_fill-1)];
    return pick_word();
  endfunction

  // --------------------------------------------------------------------------
  // Sender: optional idle cycles, then hold start until the transfer happens.
  // Called right after an edge; the transfer edge is the first one at which
  // busy was low. The model runs at that edge.
  // --------------------------------------------------------------------------
  task automatic send_action(act_t act, logic [WORD_W-1:0] word);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start     <= 1'b1;
    in_action <= act;
    in_value  <= word;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_replies.push_back(stack_apply(act, word));
  endtask

  // Sender holds off until every predicted result has come back.
  // Always advances at least one edge so start never gets two writes in a step.
  task automatic wait_for_replies();
    start <= 1'b0;
    do @(posedge clk); while (pending_replies.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Result checker: the receiver cannot stall, so every strobe is a transfer
  // --------------------------------------------------------------------------
  task automatic check_field(string name, logic [WORD_W-1:0] exp_v,
                             logic [WORD_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    stack_reply_t exp_r;
    if (rst_n && out_valid === 1'b1) begin
      replies_seen++;
      if (pending_replies.size() == 0) begin
        $display("%0t ns: result with none expected, status %h count %h",
                 $time, out_status, out_count);
        mismatches++;
      end else begin
        exp_r = pending_replies.pop_front();
        check_field("status",    exp_r.status, out_status);
        check_field("data_word", exp_r.data,   out_data_word);
        check_field("position",  exp_r.pos,    out_position);
        check_field("count",     exp_r.count,  out_count);
        check_field("is_empty",  exp_r.empty,  out_is_empty);
        check_field("top_word",  exp_r.top,    out_top_word);
      end
    end
  end

  // Watchdog: cycles without a start transfer or a result strobe
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, WATCHDOG_LIMIT, pending_replies.size());
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Corner cases: underflow, search on empty, extreme words, duplicates
  // (first match from the bottom), misses, clear leaving stale words behind
  task automatic test_directed();
    send_action(ACT_POP,    $urandom());       // pop on empty
    send_action(ACT_SEARCH, 32'h0000_0000);    // search on empty
    send_action(ACT_PUSH,   32'h7fff_ffff);
    send_action(ACT_PUSH,   32'h8000_0000);
    send_action(ACT_PUSH,   32'h0000_0000);
    send_action(ACT_PUSH,   32'hffff_ffff);
    send_action(ACT_PUSH,   32'h7fff_ffff);    // duplicate of the bottom word
    send_action(ACT_SEARCH, 32'h7fff_ffff);    // must report the bottom one
    send_action(ACT_SEARCH, 32'hffff_ffff);
    send_action(ACT_SEARCH, 32'h8000_0000);
    send_action(ACT_SEARCH, 32'h0000_0001);    // miss
    send_action(ACT_POP,    $urandom());
    send_action(ACT_POP,    $urandom());
    send_action(ACT_CLEAR,  $urandom());
    send_action(ACT_POP,    $urandom());       // pop right after clear
    send_action(ACT_SEARCH, 32'h7fff_ffff);    // stale word must not be found
    send_action(ACT_PUSH,   32'h0000_0005);
    send_action(ACT_SEARCH, 32'h0000_0005);
    send_action(ACT_POP,    $urandom());
    send_action(ACT_CLEAR,  $urandom());       // clear on empty
    send_action(ACT_PUSH,   32'h5555_5555);
    send_action(ACT_PUSH,   32'haaaa_aaaa);
    send_action(ACT_SEARCH, 32'haaaa_aaaa);
    send_action(ACT_CLEAR,  $urandom());
    wait_for_replies();
  endtask

  // Fill to depth, push against full, full-length scans, drain to underflow
  task automatic test_full_stack();
    send_action(ACT_CLEAR, $urandom());
    repeat (STACK_DEPTH - 1) send_action(ACT_PUSH, pick_word());
    send_action(ACT_PUSH, $urandom());         // top word, most likely unique
    repeat (3) send_action(ACT_PUSH, pick_word());
    send_action(ACT_SEARCH, stack_mem[STACK_DEPTH-1]);
    send_action(ACT_SEARCH, stack_mem[0]);
    send_action(ACT_SEARCH, $urandom());       // almost surely a full-depth miss
    send_action(ACT_POP,  $urandom());
    send_action(ACT_PUSH, pick_word());
    send_action(ACT_PUSH, pick_word());        // rejected, stack full again
    while (stack_fill != 0) send_action(ACT_POP, $urandom());
    send_action(ACT_POP, $urandom());
  endtask

  // Random action mix, biased toward growth; rare clears and rare pauses
  task automatic test_random_mix(int unsigned n_items);
    int unsigned r;
    repeat (n_items) begin
      r = $urandom_range(99);
      if (r < 45)      send_action(ACT_PUSH,   pick_word());
      else if (r < 72) send_action(ACT_POP,    $urandom());
      else if (r < 99) send_action(ACT_SEARCH, pick_key());
      else             send_action(ACT_CLEAR,  $urandom());
      if ($urandom_range(199) == 0) wait_for_replies();
    end
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned waited;
    waited = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender idle probability 37 percent
    idle_pct = 37;
    test_directed();
    test_random_mix(300);

    // sender idle probability 65 percent
    idle_pct = 65;
    test_random_mix(350);

    // back to back
    idle_pct = 0;
    test_full_stack();
    test_random_mix(250);

    // drain, then allow for a trailing full-depth scan
    start <= 1'b0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending_replies.size() != 0 && waited < WATCHDOG_LIMIT);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_replies.size() != 0) begin
      $display("%0t ns: %0d expected results never arrived", $time,
               pending_replies.size());
      mismatches++;
    end

    $display("Covered %0d push (%0d on full), %0d pop (%0d on empty), %0d clear,",
             n_push, n_full_reject, n_pop, n_empty_pop, n_clear);
    $display("%0d search (%0d hit, deepest at %0d, %0d miss); %0d results checked.",
             n_search, n_search_hit, deepest_hit, n_search_miss, replies_seen);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/lss_pkg.sv
design/lss_ram.sv
design/lss_scan.sv
design/lifo_stack_with_search_unit.sv
bench/tb_lifo_stack_with_search_unit.sv
